[hdl/mlrr_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduler package
// Shared sizes, operation codes, status codes and task modes.
// ----------------------------------------------------------------------------
package mlrr_pkg;

  localparam int TASKS     = 32;
  localparam int LEVELS    = 8;
  localparam int PER_LEVEL = 32;

  localparam int TW = 5;   // task index width
  localparam int LW = 3;   // level index width
  localparam int PW = 5;   // position within a level list
  localparam int CW = 6;   // level count width
  localparam int SW = 8;   // slice width
  localparam int MW = LW + PW;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_RUN    = 3'd1;
  localparam logic [2:0] OP_SLEEP  = 3'd2;
  localparam logic [2:0] OP_SWITCH = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOFREE = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_NONE   = 3'd4;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_SLEEP = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

endpackage

[hdl/mlrr_if.sv]
// ----------------------------------------------------------------------------
// Scheduler channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlrr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [4:0] task_id;
  logic [2:0] level;
  logic       keep_level;
  logic [7:0] time_slice;
  modport source(output valid, operation, task_id, level, keep_level, time_slice,
                 input ready);
  modport sink(input valid, operation, task_id, level, keep_level, time_slice,
               output ready);
endinterface

interface mlrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] granted_task;
  logic [4:0] current_task;
  logic       current_valid;
  logic [7:0] slice_out;
  logic       switched;
  modport source(output valid, status, granted_task, current_task, current_valid,
                 slice_out, switched, input ready);
  modport sink(input valid, status, granted_task, current_task, current_valid,
               slice_out, switched, output ready);
endinterface

[hdl/multilevel_round_robin_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Multilevel round robin scheduler
// Priority levels with round robin service inside a level.
// ----------------------------------------------------------------------------
// One word is handled at a time and gives one response word. A query or tick
// reads the current task, an alloc scans the task slots for a free one, and
// a sleep or a level move walks the level list in the member memory, searching
// for the entry and shifting the entries behind it down. The member memory has
// a single write port and a single read port. No clearing pass follows reset.
module multilevel_round_robin_scheduler_top
  import mlrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mlrr_req_if.sink   req,
  mlrr_rsp_if.source rsp
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BRD   = 4'd1;
  localparam logic [3:0] S_BWT   = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_ALLOC = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCMP  = 4'd6;
  localparam logic [3:0] S_RMFIX = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CWR   = 4'd9;
  localparam logic [3:0] S_RMEND = 4'd10;
  localparam logic [3:0] S_ADD   = 4'd11;
  localparam logic [3:0] S_ARD   = 4'd12;
  localparam logic [3:0] S_AWT   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0]    state;
  logic [2:0]    op;
  logic [TW-1:0] tid;
  logic [LW-1:0] lv;
  logic          keep;
  logic [SW-1:0] sl;

  logic [1:0]    mode [TASKS];
  logic [LW-1:0] home [TASKS];
  logic [SW-1:0] slc  [TASKS];
  logic [CW-1:0] cnt  [LEVELS];
  logic [PW-1:0] cur  [LEVELS];
  logic [LW:0]   act;
  logic          stale;

  logic          vb;
  logic [TW-1:0] prev_task;
  logic [CW-1:0] idx;
  logic [CW-1:0] rn;
  logic [LW-1:0] rl;
  logic          addflag;
  logic [2:0]    status;
  logic [TW-1:0] granted;

  logic          o_valid;
  logic [2:0]    o_status;
  logic [TW-1:0] o_granted;
  logic [TW-1:0] o_task;
  logic          o_cv;
  logic [SW-1:0] o_slice;
  logic          o_sw;

  logic          we;
  logic [MW-1:0] waddr;
  logic [TW-1:0] wdata;
  logic [MW-1:0] raddr;
  logic [TW-1:0] rdata;

  logic [LW:0]   resel;
  logic          cur_ok;
  logic [LW-1:0] target;
  logic          move;
  logic [CW-1:0] adv;
  logic [CW-1:0] nn;
  logic [PW-1:0] cfix;
  logic [PW-1:0] cdec;
  logic          va_end;
  logic [TW-1:0] after;

  mlrr_ram #(.WIDTH(TW), .DEPTH(LEVELS * PER_LEVEL)) u_members (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    resel = (LW + 1)'(LEVELS);
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt[l] != '0) begin
        resel = (LW + 1)'(l);
      end
    end
  end

  always_comb begin
    cur_ok = (act < (LW + 1)'(LEVELS)) && (cnt[act[LW-1:0]] != '0);
    target = keep ? home[tid] : lv;
    move   = (mode[tid] != MODE_RUN) || (home[tid] != target);
    adv    = CW'(cur[act[LW-1:0]]) + CW'(1);
    nn     = (cnt[rl] != '0) ? cnt[rl] - CW'(1) : '0;
    cdec   = (idx < CW'(cur[rl])) ? cur[rl] - PW'(1) : cur[rl];
    cfix   = (CW'(cdec) >= nn) ? '0 : cdec;
    va_end = (state == S_AWT);
    after  = va_end ? rdata : '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = {rl, cnt[rl][PW-1:0]};
    wdata = tid;
    raddr = {act[LW-1:0], cur[act[LW-1:0]]};
    unique case (state)
      S_SRD:   raddr = {rl, idx[PW-1:0]};
      S_CRD:   raddr = {rl, idx[PW-1:0] + PW'(1)};
      S_CWR: begin
        we    = 1'b1;
        waddr = {rl, idx[PW-1:0]};
        wdata = rdata;
      end
      S_ADD:   we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      act     <= (LW + 1)'(LEVELS);
      stale   <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        mode[i] <= MODE_FREE;
        home[i] <= '0;
        slc[i]  <= '0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        cnt[l] <= '0;
        cur[l] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.operation;
            tid   <= req.task_id;
            lv    <= req.level;
            keep  <= req.keep_level;
            sl    <= req.time_slice;
            state <= S_BRD;
          end
        end
        S_BRD: begin
          vb    <= 1'b0;
          state <= cur_ok ? S_BWT : S_DISP;
        end
        S_BWT: begin
          vb        <= 1'b1;
          prev_task <= rdata;
          state     <= S_DISP;
        end
        S_DISP: begin
          status  <= ST_OK;
          granted <= '0;
          idx     <= '0;
          state   <= S_ARD;
          case (op)
            OP_ALLOC: state <= S_ALLOC;
            OP_RUN: begin
              if (mode[tid] == MODE_FREE) begin
                status <= ST_BAD;
              end else if (move && cnt[target] >= CW'(PER_LEVEL)) begin
                status <= ST_FULL;
              end else begin
                if (sl != '0) begin
                  slc[tid] <= sl;
                end
                stale <= 1'b1;
                lv    <= target;
                if (mode[tid] == MODE_RUN && home[tid] != target) begin
                  rl      <= home[tid];
                  addflag <= 1'b1;
                  state   <= S_SRD;
                end else if (mode[tid] != MODE_RUN) begin
                  home[tid] <= target;
                  rl        <= target;
                  state     <= S_ADD;
                end
              end
            end
            OP_SLEEP: begin
              if (mode[tid] != MODE_RUN) begin
                status <= ST_BAD;
              end else begin
                rl      <= home[tid];
                addflag <= 1'b0;
                state   <= S_SRD;
              end
            end
            OP_SWITCH: begin
              if (cur_ok) begin
                cur[act[LW-1:0]] <= (adv >= cnt[act[LW-1:0]]) ? '0 : adv[PW-1:0];
              end
              if (stale) begin
                act   <= resel;
                stale <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_ALLOC: begin
          if (idx == CW'(TASKS)) begin
            status <= ST_NOFREE;
            state  <= S_ARD;
          end else if (mode[idx[TW-1:0]] == MODE_FREE) begin
            mode[idx[TW-1:0]] <= MODE_SLEEP;
            granted           <= idx[TW-1:0];
            state             <= S_ARD;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SRD: begin
          state <= (idx >= cnt[rl]) ? S_RMFIX : S_SCMP;
        end
        S_SCMP: begin
          if (rdata == tid) begin
            state <= S_RMFIX;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SRD;
          end
        end
        S_RMFIX: begin
          cnt[rl]   <= nn;
          cur[rl]   <= cfix;
          rn        <= nn;
          mode[tid] <= MODE_SLEEP;
          state     <= S_CRD;
        end
        S_CRD: begin
          state <= (idx < rn) ? S_CWR : S_RMEND;
        end
        S_CWR: begin
          idx   <= idx + CW'(1);
          state <= S_CRD;
        end
        S_RMEND: begin
          state <= S_ARD;
          if (addflag) begin
            home[tid] <= lv;
            rl        <= lv;
            state     <= S_ADD;
          end else if (vb && prev_task == tid) begin
            act   <= resel;
            stale <= 1'b0;
          end
        end
        S_ADD: begin
          cnt[rl]   <= cnt[rl] + CW'(1);
          mode[tid] <= MODE_RUN;
          state     <= S_ARD;
        end
        S_ARD: begin
          state <= cur_ok ? S_AWT : S_OUT;
          if (!cur_ok) begin
            o_valid   <= 1'b1;
            o_status  <= (op == OP_SWITCH || op >= OP_QUERY) ? ST_NONE : status;
            o_granted <= granted;
            o_task    <= '0;
            o_cv      <= 1'b0;
            o_slice   <= '0;
            o_sw      <= vb;
          end
        end
        S_AWT: begin
          o_valid   <= 1'b1;
          o_status  <= status;
          o_granted <= granted;
          o_task    <= after;
          o_cv      <= va_end;
          o_slice   <= slc[after];
          o_sw      <= !vb || (after != prev_task);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            o_valid <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.granted_task  = o_granted;
  assign rsp.current_task  = o_task;
  assign rsp.current_valid = o_cv;
  assign rsp.slice_out     = o_slice;
  assign rsp.switched      = o_sw;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("accepting while a response waits");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_BRD)) else $error("accept not started");

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    act <= (LW + 1)'(LEVELS)) else $error("active level out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.current_valid) |-> (rsp.current_task == '0 && rsp.slice_out == '0))
    else $error("idle response carries a task");

endmodule

[hdl/mlrr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives request words into the multilevel round robin scheduler and checks
// every response word against a behavioral model of the task lists.
// ----------------------------------------------------------------------------
module tb_top;
  import mlrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] granted_task;
    logic [4:0] current_task;
    logic       current_valid;
    logic [7:0] slice_out;
    logic       switched;
  } sched_rsp_t;

  class sched_scoreboard;
    logic [1:0] mode [TASKS];
    logic [2:0] home [TASKS];
    logic [7:0] slice [TASKS];
    logic [4:0] members [LEVELS][PER_LEVEL];
    int unsigned count [LEVELS];
    int unsigned cursor [LEVELS];
    int unsigned active;
    bit stale;
    sched_rsp_t pending [$];
    int errors;
    int results;

    function new();
      for (int i = 0; i < TASKS; i++) begin
        mode[i] = MODE_FREE;
        home[i] = '0;
        slice[i] = '0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        count[l] = 0;
        cursor[l] = 0;
        for (int j = 0; j < PER_LEVEL; j++) members[l][j] = '0;
      end
      active = LEVELS;
      stale = 0;
      errors = 0;
      results = 0;
    endfunction

    function void pick_level();
      int unsigned l;
      l = 0;
      while (l < LEVELS && count[l] == 0) l++;
      active = l;
      stale = 0;
    endfunction

    function bit current(output logic [4:0] t);
      t = '0;
      if (active >= LEVELS || count[active] == 0) return 0;
      t = members[active][cursor[active] % PER_LEVEL];
      return 1;
    endfunction

    function void enqueue(int unsigned t);
      int unsigned l;
      l = home[t];
      members[l][count[l] % PER_LEVEL] = t[4:0];
      count[l]++;
      mode[t] = MODE_RUN;
    endfunction

    function void unlink(int unsigned t);
      int unsigned l, n, i;
      l = home[t];
      n = count[l];
      i = 0;
      while (i < n && members[l][i] != t[4:0]) i++;
      if (n > 0) n--;
      count[l] = n;
      if (i < cursor[l]) cursor[l]--;
      if (cursor[l] >= n) cursor[l] = 0;
      for (; i < n && i + 1 < PER_LEVEL; i++) members[l][i] = members[l][i + 1];
      mode[t] = MODE_SLEEP;
    endfunction

    function void note_request(logic [2:0] op, logic [4:0] t, logic [2:0] lv,
                               logic keep, logic [7:0] sl);
      sched_rsp_t r;
      logic [4:0] prev, now;
      bit vb, va, move;
      int unsigned tgt, i;
      r = '0;
      vb = current(prev);
      case (op)
        OP_ALLOC: begin
          i = 0;
          while (i < TASKS && mode[i] != MODE_FREE) i++;
          if (i < TASKS) begin
            mode[i] = MODE_SLEEP;
            r.granted_task = i[4:0];
          end else r.status = ST_NOFREE;
        end
        OP_RUN: begin
          if (mode[t] == MODE_FREE) r.status = ST_BAD;
          else begin
            tgt = keep ? home[t] : lv;
            move = mode[t] != MODE_RUN || home[t] != tgt;
            if (move && count[tgt] >= PER_LEVEL) r.status = ST_FULL;
            else begin
              if (sl != 0) slice[t] = sl;
              if (mode[t] == MODE_RUN && home[t] != tgt) unlink(t);
              if (mode[t] != MODE_RUN) begin
                home[t] = tgt[2:0];
                enqueue(t);
              end
              stale = 1;
            end
          end
        end
        OP_SLEEP: begin
          if (mode[t] != MODE_RUN) r.status = ST_BAD;
          else begin
            unlink(t);
            if (vb && prev == t) pick_level();
          end
        end
        OP_SWITCH: begin
          if (active < LEVELS && count[active] > 0) begin
            cursor[active]++;
            if (cursor[active] >= count[active]) cursor[active] = 0;
          end
          if (stale) pick_level();
          if (!current(now)) r.status = ST_NONE;
        end
        default: if (!current(now)) r.status = ST_NONE;
      endcase
      va = current(now);
      r.current_task = va ? now : '0;
      r.current_valid = va;
      r.slice_out = va ? slice[now] : '0;
      r.switched = (va != vb) || (va && now != prev);
      pending.push_back(r);
    endfunction

    function void check_response(sched_rsp_t got);
      sched_rsp_t e;
      results++;
      if (pending.size() == 0) begin
        $error("response word with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.granted_task !== e.granted_task) begin
        $error("granted_task: expected %0d, got %0d", e.granted_task, got.granted_task);
        errors++;
      end
      if (got.current_task !== e.current_task) begin
        $error("current_task: expected %0d, got %0d", e.current_task, got.current_task);
        errors++;
      end
      if (got.current_valid !== e.current_valid) begin
        $error("current_valid: expected %0d, got %0d", e.current_valid,
               got.current_valid);
        errors++;
      end
      if (got.slice_out !== e.slice_out) begin
        $error("slice_out: expected %0d, got %0d", e.slice_out, got.slice_out); errors++;
      end
      if (got.switched !== e.switched) begin
        $error("switched: expected %0d, got %0d", e.switched, got.switched); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  mlrr_req_if req ();
  mlrr_rsp_if rsp ();

  multilevel_round_robin_scheduler_top uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  sched_scoreboard sb;
  bit calm;
  int idle_cycles;
  int sent;
  localparam int WATCHDOG = 5000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    req.valid = 0;
    req.operation = '0;
    req.task_id = '0;
    req.level = '0;
    req.keep_level = 0;
    req.time_slice = '0;
    rsp.ready = 0;
    rst = 1;
    calm = 0;
    sb = new();
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_response({rsp.status, rsp.granted_task, rsp.current_task,
                         rsp.current_valid, rsp.slice_out, rsp.switched});
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 0;
    else rsp.ready <= calm || ($urandom_range(99) >= 35);
  end

  task automatic send_word(logic [2:0] op, logic [4:0] t, logic [2:0] lv, logic keep,
                           logic [7:0] sl);
    while (!calm && $urandom_range(99) < 35) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1;
    req.operation <= op;
    req.task_id <= t;
    req.level <= lv;
    req.keep_level <= keep;
    req.time_slice <= sl;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, t, lv, keep, sl);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned p;
    logic [2:0] op;
    p = $urandom_range(99);
    if (p < 12) op = OP_ALLOC;
    else if (p < 45) op = OP_RUN;
    else if (p < 62) op = OP_SLEEP;
    else if (p < 85) op = OP_SWITCH;
    else if (p < 95) op = OP_QUERY;
    else op = 3'($urandom_range(7, 5));
    send_word(op, 5'($urandom), 3'($urandom), $urandom_range(3) == 0,
              ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
  endtask

  initial begin
    idle_cycles = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_word(OP_QUERY, 0, 0, 0, 0);
    send_word(OP_SWITCH, 0, 0, 0, 0);
    send_word(OP_RUN, 0, 0, 0, 8'd5);
    send_word(OP_SLEEP, 5'd31, 0, 0, 0);
    send_word(OP_ALLOC, 0, 0, 0, 0);
    send_word(OP_ALLOC, 0, 0, 0, 0);
    send_word(OP_RUN, 0, 3'd7, 0, 8'd255);
    send_word(OP_RUN, 1, 3'd7, 0, 8'd1);
    send_word(OP_SWITCH, 0, 0, 0, 0);
    send_word(OP_RUN, 1, 3'd0, 0, 8'd0);
    send_word(OP_RUN, 1, 3'd5, 1, 8'd9);
    send_word(OP_SWITCH, 0, 0, 0, 0);
    send_word(OP_SLEEP, 1, 0, 0, 0);
    send_word(OP_SLEEP, 1, 0, 0, 0);
    send_word(3'd5, 0, 0, 0, 0);
    send_word(3'd7, 0, 0, 0, 0);
    for (int i = 0; i < 31; i++) send_word(OP_ALLOC, 0, 0, 0, 0);
    for (int i = 0; i < 32; i++) send_word(OP_RUN, 5'(i), 3'd2, 0, 8'(i + 1));
    send_word(OP_SWITCH, 0, 0, 0, 0);
    send_word(OP_SLEEP, 5'd31, 0, 0, 0);
    send_word(OP_RUN, 5'd31, 3'd2, 0, 0);
    for (int i = 0; i < 40; i++) send_word(OP_SWITCH, 0, 0, 0, 0);

    for (int i = 0; i < 680; i++) begin
      calm = (i >= 300 && i < 400);
      send_random();
    end
    calm = 0;
    req.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d request words through alloc, run, sleep, tick and query;", sent);
    $display("%0d response words compared, %0d field errors.", sb.results, sb.errors);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
